// File: hdl/nrmc_pkg.sv
package nrmc_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned MIN_FRAC_DIGITS_DEF = 4;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;

    // Field widths.
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned UTC_W      = 18;
    localparam int unsigned LAT_W      = 28;
    localparam int unsigned LON_W      = 29;
    localparam int unsigned THR_W      = 28;
    localparam int unsigned MIN_W      = 20;
    localparam int unsigned LAT_DEG_W  = 7;
    localparam int unsigned LON_DEG_W  = 8;
    localparam int unsigned MAG_W      = 28;
    localparam int unsigned OUT_DATA_W = 80;

    // Limits and reset values.
    localparam logic [THR_W-1:0] THR_RESET  = 28'd1000000;
    localparam logic [UTC_W-1:0] TIME_MAX   = 18'd235959;
    localparam logic [MIN_W-1:0] MINUTE_MAX = '1;
    localparam logic [MAG_W-1:0] LAT_LIMIT  = 28'd90000000;
    localparam logic [MAG_W-1:0] LON_LIMIT  = 28'd180000000;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_COMMA   = 2'd1,
        ST_FEW_COMMAS = 2'd2
    } t_status;

    // Sentence field selected by the number of commas seen so far.
    localparam logic [2:0] FLD_PREFIX = 3'd0;
    localparam logic [2:0] FLD_TIME   = 3'd1;
    localparam logic [2:0] FLD_STATUS = 3'd2;
    localparam logic [2:0] FLD_LAT    = 3'd3;
    localparam logic [2:0] FLD_NS     = 3'd4;
    localparam logic [2:0] FLD_LON    = 3'd5;
    localparam logic [2:0] FLD_EW     = 3'd6;
    localparam logic [2:0] FLD_TAIL   = 3'd7;

    // ASCII characters of interest.
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h57;

    // One parsed sentence, handed from the parser to the converter.
    typedef struct packed {
        t_status              status;
        logic                 fix_valid;
        logic [UTC_W-1:0]     utc;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
        logic                 south;
        logic                 west;
    } t_record;

    // Power of ten, for constant tables only.
    function automatic int unsigned pow10(input int unsigned n);
        int unsigned p;
        p = 1;
        for (int unsigned i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

// File: hdl/nrmc_front.sv
module nrmc_front #(
    parameter int unsigned MINUTE_FRACTION_DIGITS = nrmc_pkg::MIN_FRAC_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [nrmc_pkg::CHAR_W-1:0]   i_char,
    input  logic                          i_last,
    input  logic                          i_locked,
    output logic                          o_push,
    output nrmc_pkg::t_record             o_rec
);
    import nrmc_pkg::*;

    // Working view of one coordinate field and the shared digit counters.
    typedef struct packed {
        logic [LON_DEG_W-1:0] deg;
        logic [MIN_W-1:0]     mins;
        logic [3:0]           fdc;
        logic [2:0]           frc;
    } t_coord;

    localparam logic [2:0]  FRAC_DIGITS    = 3'(MINUTE_FRACTION_DIGITS);
    localparam logic [24:0] INT_WEIGHT     = 25'(pow10(MINUTE_FRACTION_DIGITS));
    localparam logic [3:0]  FDC_MAX        = 4'd15;
    localparam logic [2:0]  FRC_MAX        = 3'd7;
    localparam logic [3:0]  TIME_DIGITS    = 4'd6;
    localparam logic [3:0]  LAT_DEG_DIGITS = 4'd2;
    localparam logic [3:0]  LON_DEG_DIGITS = 4'd3;
    localparam logic [7:0]  LAT_DEG_MAX    = 8'd99;
    localparam logic [7:0]  LON_DEG_MAX    = 8'd255;

    // Sentence state.
    logic [2:0]           r_comma;
    logic [UTC_W-1:0]     r_time;
    logic                 r_time_frac;
    logic                 r_valid;
    logic [LAT_DEG_W-1:0] r_lat_deg;
    logic [MIN_W-1:0]     r_lat_min;
    logic [LON_DEG_W-1:0] r_lon_deg;
    logic [MIN_W-1:0]     r_lon_min;
    logic [3:0]           r_fdc;
    logic [2:0]           r_frc;
    logic                 r_south;
    logic                 r_west;

    // State after the current character.
    logic [2:0]           n_comma;
    logic [UTC_W-1:0]     n_time;
    logic                 n_time_frac;
    logic                 n_valid;
    logic [LAT_DEG_W-1:0] n_lat_deg;
    logic [MIN_W-1:0]     n_lat_min;
    logic [LON_DEG_W-1:0] n_lon_deg;
    logic [MIN_W-1:0]     n_lon_min;
    logic [3:0]           n_fdc;
    logic [2:0]           n_frc;
    logic                 n_south;
    logic                 n_west;

    logic [24:0] w_frac_weight [0:7];
    logic        w_is_digit;
    logic [21:0] w_time_ext;
    logic        w_take;
    logic        w_ok;
    t_coord      w_lat_in;
    t_coord      w_lat_nx;
    t_coord      w_lon_in;
    t_coord      w_lon_nx;

    // Weight of a minute fraction digit, indexed by digits still to come.
    for (genvar g = 0; g < 8; g++) begin : g_weight
        assign w_frac_weight[g] = 25'(pow10(g));
    end

    // One character of a coordinate field.
    function automatic t_coord coord_step(
        input t_coord             cur,
        input logic [CHAR_W-1:0]  c,
        input logic [3:0]         deg_digits,
        input logic [7:0]         deg_max,
        input logic [24:0]        frac_w
    );
        t_coord      nxt;
        logic [24:0] m;
        logic [11:0] dg;
        logic [24:0] d;
        nxt = cur;
        m   = '0;
        dg  = '0;
        d   = 25'(c[3:0]);
        if (c == CH_DOT) begin
            if (cur.frc == '0) begin
                nxt.frc = 3'd1;
            end
        end else if (c inside {[CH_0:CH_9]}) begin
            if (cur.frc != '0) begin
                // Fraction digit: add in at its weight, drop those past the precision.
                if (cur.frc <= FRAC_DIGITS) begin
                    m = 25'(cur.mins) + d * frac_w;
                    nxt.mins = (m > 25'(MINUTE_MAX)) ? MINUTE_MAX : m[MIN_W-1:0];
                end
                if (cur.frc != FRC_MAX) begin
                    nxt.frc = cur.frc + 3'd1;
                end
            end else if (cur.fdc < deg_digits) begin
                dg = 12'(cur.deg) * 12'd10 + 12'(d);
                nxt.deg = (dg > 12'(deg_max)) ? deg_max : dg[7:0];
                if (cur.fdc != FDC_MAX) begin
                    nxt.fdc = cur.fdc + 4'd1;
                end
            end else begin
                m = 25'(cur.mins) * 25'd10 + d * INT_WEIGHT;
                nxt.mins = (m > 25'(MINUTE_MAX)) ? MINUTE_MAX : m[MIN_W-1:0];
                if (cur.fdc != FDC_MAX) begin
                    nxt.fdc = cur.fdc + 4'd1;
                end
            end
        end
        return nxt;
    endfunction

    assign w_take = i_take & ~i_locked;

    // Candidate updates for the coordinate and time fields.
    always_comb begin
        w_is_digit = i_char inside {[CH_0:CH_9]};
        w_time_ext = 22'(r_time) * 22'd10 + 22'(i_char[3:0]);
        w_lat_in   = '{deg: 8'(r_lat_deg), mins: r_lat_min, fdc: r_fdc, frc: r_frc};
        w_lon_in   = '{deg: r_lon_deg, mins: r_lon_min, fdc: r_fdc, frc: r_frc};
        w_lat_nx   = coord_step(w_lat_in, i_char, LAT_DEG_DIGITS, LAT_DEG_MAX,
                                w_frac_weight[FRAC_DIGITS - r_frc]);
        w_lon_nx   = coord_step(w_lon_in, i_char, LON_DEG_DIGITS, LON_DEG_MAX,
                                w_frac_weight[FRAC_DIGITS - r_frc]);
    end

    // Next sentence state for the current character.
    always_comb begin
        n_comma     = r_comma;
        n_time      = r_time;
        n_time_frac = r_time_frac;
        n_valid     = r_valid;
        n_lat_deg   = r_lat_deg;
        n_lat_min   = r_lat_min;
        n_lon_deg   = r_lon_deg;
        n_lon_min   = r_lon_min;
        n_fdc       = r_fdc;
        n_frc       = r_frc;
        n_south     = r_south;
        n_west      = r_west;
        if (i_char == CH_COMMA) begin
            if (r_comma != FLD_TAIL) begin
                n_comma = r_comma + 3'd1;
            end
            n_fdc = '0;
            n_frc = '0;
        end else begin
            case (r_comma)
                FLD_TIME: begin
                    if (i_char == CH_DOT) begin
                        n_time_frac = 1'b1;
                    end else if (w_is_digit && !r_time_frac && r_fdc < TIME_DIGITS) begin
                        n_time = (w_time_ext > 22'(TIME_MAX)) ? TIME_MAX
                                                             : w_time_ext[UTC_W-1:0];
                        n_fdc  = r_fdc + 4'd1;
                    end
                end
                FLD_STATUS: begin
                    if (r_fdc == '0) begin
                        n_valid = (i_char == CH_A);
                    end
                    if (r_fdc != FDC_MAX) begin
                        n_fdc = r_fdc + 4'd1;
                    end
                end
                FLD_LAT: begin
                    n_lat_deg = w_lat_nx.deg[LAT_DEG_W-1:0];
                    n_lat_min = w_lat_nx.mins;
                    n_fdc     = w_lat_nx.fdc;
                    n_frc     = w_lat_nx.frc;
                end
                FLD_NS: begin
                    if (r_fdc == '0) begin
                        n_south = (i_char == CH_S);
                    end
                    if (r_fdc != FDC_MAX) begin
                        n_fdc = r_fdc + 4'd1;
                    end
                end
                FLD_LON: begin
                    n_lon_deg = w_lon_nx.deg;
                    n_lon_min = w_lon_nx.mins;
                    n_fdc     = w_lon_nx.fdc;
                    n_frc     = w_lon_nx.frc;
                end
                FLD_EW: begin
                    if (r_fdc == '0) begin
                        n_west = (i_char == CH_W);
                    end
                    if (r_fdc != FDC_MAX) begin
                        n_fdc = r_fdc + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Sentence registers; the last character clears them for the next sentence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && i_last)) begin
            r_comma     <= '0;
            r_time      <= '0;
            r_time_frac <= 1'b0;
            r_valid     <= 1'b0;
            r_lat_deg   <= '0;
            r_lat_min   <= '0;
            r_lon_deg   <= '0;
            r_lon_min   <= '0;
            r_fdc       <= '0;
            r_frc       <= '0;
            r_south     <= 1'b0;
            r_west      <= 1'b0;
        end else if (w_take) begin
            r_comma     <= n_comma;
            r_time      <= n_time;
            r_time_frac <= n_time_frac;
            r_valid     <= n_valid;
            r_lat_deg   <= n_lat_deg;
            r_lat_min   <= n_lat_min;
            r_lon_deg   <= n_lon_deg;
            r_lon_min   <= n_lon_min;
            r_fdc       <= n_fdc;
            r_frc       <= n_frc;
            r_south     <= n_south;
            r_west      <= n_west;
        end
    end

    // Finished sentence; fields read as zero unless all seven commas came.
    always_comb begin
        w_ok              = (n_comma == FLD_TAIL);
        o_push            = w_take & i_last;
        o_rec.status      = (n_comma == FLD_PREFIX) ? ST_NO_COMMA
                          : (w_ok ? ST_OK : ST_FEW_COMMAS);
        o_rec.fix_valid   = w_ok & n_valid;
        o_rec.utc         = w_ok ? n_time : '0;
        o_rec.lat_deg     = w_ok ? n_lat_deg : '0;
        o_rec.lat_min     = w_ok ? n_lat_min : '0;
        o_rec.lon_deg     = w_ok ? n_lon_deg : '0;
        o_rec.lon_min     = w_ok ? n_lon_min : '0;
        o_rec.south       = w_ok & n_south;
        o_rec.west        = w_ok & n_west;
    end

endmodule

// File: hdl/nrmc_fifo.sv
module nrmc_fifo #(
    parameter int unsigned DEPTH = nrmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nrmc_pkg::t_record i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output nrmc_pkg::t_record o_rec
);
    import nrmc_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PTR_LAST = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CNT_FULL = CntW'(DEPTH);
    localparam logic [PtrW-1:0] PTR_ONE  = PtrW'(1);
    localparam logic [CntW-1:0] CNT_ONE  = CntW'(1);

    t_record         r_mem [0:DEPTH-1];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_ONE;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_ONE;
            end
        end
    end

endmodule

// File: hdl/nrmc_back.sv
module nrmc_back #(
    parameter int unsigned MINUTE_FRACTION_DIGITS = nrmc_pkg::MIN_FRAC_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nrmc_pkg::THR_W-1:0]        i_cfg_wdata,
    input  logic                              i_vld,
    input  nrmc_pkg::t_record                 i_rec,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [nrmc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic [nrmc_pkg::STATUS_W-1:0]     o_m_tuser,
    output logic                              o_locked
);
    import nrmc_pkg::*;

    // Minutes to micro-degrees is mins * ScaleK / 60, split as
    // (mins / 60) * ScaleK plus a table entry for the remainder.
    localparam int unsigned ScaleK     = pow10(6 - MINUTE_FRACTION_DIGITS);
    localparam int unsigned RecipShift = 26;
    localparam int unsigned RecipW     = 21;
    localparam int unsigned ProdW      = MIN_W + RecipW;
    localparam int unsigned QW         = 15;
    localparam int unsigned SumW       = 32;
    localparam logic [RecipW-1:0] RECIP_60    = 21'd1118482;
    localparam logic [20:0]       MIN_PER_DEG = 21'd60;
    localparam logic [QW-1:0]     Q_ONE       = QW'(1);
    localparam int unsigned LANE_LAT = 0;
    localparam int unsigned LANE_LON = 1;

    typedef struct packed {
        t_status          status;
        logic             fix_valid;
        logic [UTC_W-1:0] utc;
        logic             south;
        logic             west;
    } t_side;

    logic [THR_W-1:0]     r_thr;
    logic                 r_locked;
    logic                 w_adv;
    logic                 w_hit;
    logic                 w_lock_next;

    logic                 r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;
    t_side                r_s1_side, r_s2_side, r_s3_side, r_s4_side;

    logic [LON_DEG_W-1:0] w_deg      [0:1];
    logic [MIN_W-1:0]     w_min      [0:1];
    logic [MAG_W-1:0]     w_limit    [0:1];
    logic [ProdW-1:0]     r_s1_prod  [0:1];
    logic [MAG_W-1:0]     r_s1_degus [0:1];
    logic [MIN_W-1:0]     r_s1_mins  [0:1];
    logic [QW-1:0]        w_q_raw    [0:1];
    logic [20:0]          w_rem_raw  [0:1];
    logic [QW-1:0]        r_s2_q     [0:1];
    logic [5:0]           r_s2_r     [0:1];
    logic [MAG_W-1:0]     r_s2_degus [0:1];
    logic [SumW-1:0]      r_s3_qk    [0:1];
    logic [SumW-1:0]      r_s3_rem   [0:1];
    logic [MAG_W-1:0]     r_s3_degus [0:1];
    logic [SumW-1:0]      w_sum      [0:1];
    logic [MAG_W-1:0]     r_s4_mag   [0:1];
    logic [SumW-1:0]      w_rem_tab  [0:63];
    logic [LAT_W-1:0]     w_lat_bits;
    logic [LON_W-1:0]     w_lon_bits;

    logic [OUT_DATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0]   r_out_user;

    // Remainder table: micro-degrees of 0 to 59 minute units.
    for (genvar g = 0; g < 64; g++) begin : g_rem
        localparam int unsigned RemVal = (g < 60) ? (g * ScaleK) / 60 : 0;
        assign w_rem_tab[g] = SumW'(RemVal);
    end

    // The whole pipeline moves when the output slot is free or being taken.
    assign w_adv  = ~r_out_vld | i_m_tready;
    assign o_pop  = w_adv & i_vld;

    // Lane inputs and the quotient/remainder step.
    always_comb begin
        w_deg[LANE_LAT]   = 8'(i_rec.lat_deg);
        w_deg[LANE_LON]   = i_rec.lon_deg;
        w_min[LANE_LAT]   = i_rec.lat_min;
        w_min[LANE_LON]   = i_rec.lon_min;
        w_limit[LANE_LAT] = LAT_LIMIT;
        w_limit[LANE_LON] = LON_LIMIT;
        for (int l = 0; l < 2; l++) begin
            w_q_raw[l]   = r_s1_prod[l][RecipShift +: QW];
            w_rem_raw[l] = 21'(r_s1_mins[l]) - ((21'(w_q_raw[l]) << 6) - (21'(w_q_raw[l]) << 2));
            w_sum[l]     = SumW'(r_s3_degus[l]) + r_s3_qk[l] + r_s3_rem[l];
        end
    end

    // Lock test and signed results.
    always_comb begin
        w_hit = ~r_s4_side.south & ~r_s4_side.west
              & (r_s4_mag[LANE_LAT] > r_thr) & (r_s4_mag[LANE_LON] > r_thr);
        w_lock_next = r_locked | w_hit;
        w_lat_bits  = r_s4_side.south ? (LAT_W'(0) - LAT_W'(r_s4_mag[LANE_LAT]))
                                      : LAT_W'(r_s4_mag[LANE_LAT]);
        w_lon_bits  = r_s4_side.west  ? (LON_W'(0) - LON_W'(r_s4_mag[LANE_LON]))
                                      : LON_W'(r_s4_mag[LANE_LON]);
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_side <= '{status: i_rec.status, fix_valid: i_rec.fix_valid, utc: i_rec.utc,
                           south: i_rec.south, west: i_rec.west};
            r_s2_side <= r_s1_side;
            r_s3_side <= r_s2_side;
            r_s4_side <= r_s3_side;
            for (int l = 0; l < 2; l++) begin
                // Multiply by the reciprocal of 60, and degrees to micro-degrees.
                r_s1_prod[l]  <= ProdW'(w_min[l]) * ProdW'(RECIP_60);
                r_s1_degus[l] <= MAG_W'(w_deg[l]) * MAG_W'(1000000);
                r_s1_mins[l]  <= w_min[l];
                // Correct a quotient that came out one low.
                if (w_rem_raw[l] >= MIN_PER_DEG) begin
                    r_s2_q[l] <= w_q_raw[l] + Q_ONE;
                    r_s2_r[l] <= 6'(w_rem_raw[l] - MIN_PER_DEG);
                end else begin
                    r_s2_q[l] <= w_q_raw[l];
                    r_s2_r[l] <= w_rem_raw[l][5:0];
                end
                r_s2_degus[l] <= r_s1_degus[l];
                // Whole degrees of minutes, and the remainder from the table.
                r_s3_qk[l]    <= SumW'(r_s2_q[l]) * SumW'(ScaleK);
                r_s3_rem[l]   <= w_rem_tab[r_s2_r[l]];
                r_s3_degus[l] <= r_s2_degus[l];
                // Sum and clamp.
                r_s4_mag[l]   <= (w_sum[l] > SumW'(w_limit[l])) ? w_limit[l]
                                                               : w_sum[l][MAG_W-1:0];
            end
        end
        if (w_adv && r_s4_vld && !r_locked) begin
            r_out_data <= {3'b000, w_lock_next, w_lon_bits, w_lat_bits,
                           r_s4_side.utc, r_s4_side.fix_valid};
            r_out_user <= r_s4_side.status;
        end
    end

    // Stage valids, lock flag and threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_locked  <= 1'b0;
            r_thr     <= THR_RESET;
        end else begin
            if (w_adv) begin
                r_s1_vld  <= i_vld;
                r_s2_vld  <= r_s1_vld;
                r_s3_vld  <= r_s2_vld;
                r_s4_vld  <= r_s3_vld;
                // Sentences behind the one that set the lock are dropped.
                r_out_vld <= r_s4_vld & ~r_locked;
                if (r_s4_vld) begin
                    r_locked <= w_lock_next;
                end
            end
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_locked   = r_locked;

endmodule

// File: hdl/nmea_rmc_position_parser_core.sv
// RMC sentence parser: takes one character per clock on the input stream while the queue
// has room and, on the character marked by tlast, produces one result item with the UTC
// time, the fix status and signed micro-degree latitude and longitude. Results leave
// through a five-stage conversion pipeline that accepts a new sentence every cycle
// unless the result stream stalls. A four-entry queue sits between the character parser
// and the converter, so the input keeps flowing while results wait at the output. Once a
// sentence sets the position lock, all further input is taken and ignored until reset; a
// threshold write does not clear the lock.
module nmea_rmc_position_parser_core #(
    parameter int unsigned MINUTE_FRACTION_DIGITS = nrmc_pkg::MIN_FRAC_DIGITS_DEF,
    parameter int unsigned QUEUE_DEPTH            = nrmc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Lock threshold in micro-degrees.
    input  logic                            i_cfg_we,
    input  logic [nrmc_pkg::THR_W-1:0]      i_cfg_wdata,
    // Character stream; tlast marks the last character of a sentence.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [nrmc_pkg::CHAR_W-1:0]     i_s_tdata,   // [7:0] char_byte
    input  logic                            i_s_tlast,
    // Result stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [nrmc_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [0] fix_valid, [18:1] utc_hhmmss,
                                                         // [46:19] latitude_microdeg,
                                                         // [75:47] longitude_microdeg,
                                                         // [76] position_locked, [79:77] zero
    output logic [nrmc_pkg::STATUS_W-1:0]   o_m_tuser    // [1:0] parse_status
);
    import nrmc_pkg::*;

    logic    w_take;
    logic    w_push;
    logic    w_full;
    logic    w_locked;
    logic    w_q_vld;
    logic    w_pop;
    t_record w_rec_in;
    t_record w_rec_out;

    // While locked nothing is queued, so input is always taken.
    assign o_s_tready = ~w_full | w_locked;
    assign w_take     = i_s_tvalid & o_s_tready;

    nrmc_front #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_char   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_locked (w_locked),
        .o_push   (w_push),
        .o_rec    (w_rec_in)
    );

    nrmc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_vld),
        .o_rec   (w_rec_out)
    );

    nrmc_back #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_vld       (w_q_vld),
        .i_rec       (w_rec_out),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_locked    (w_locked)
    );

    // The lock, once set, holds until reset.
    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_locked |=> w_locked)
        else $error("position lock dropped without reset");

    // No sentence is queued once the lock is set.
    a_no_push_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_locked |-> !w_push)
        else $error("sentence queued while locked");

    // A sentence with a parse error carries only zero fields and never locks.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata == '0))
        else $error("parse error result carries non-zero fields");

endmodule

// File: tb/sv/tb_nmea_rmc_position_parser_core.sv
module tb_nmea_rmc_position_parser_core;
    import nrmc_pkg::*;

    localparam int FRAC_DIGITS  = MIN_FRAC_DIGITS_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASE_CHARS  = 330;
    localparam int DIR_ROWS     = 6;
    localparam logic [THR_W-1:0] THR_TOP = 28'd180000000;
    localparam logic [CHAR_W-1:0] CH_E    = 8'h45;
    localparam logic [CHAR_W-1:0] CH_N    = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
    localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;

    // One converted position fix, as it leaves the block.
    typedef struct packed {
        t_status          status;
        logic             fix;
        logic [UTC_W-1:0] utc;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic             locked;
    } t_rmc_result;

    // Parsing progress within the current sentence.
    typedef struct packed {
        logic [2:0]           commas;
        logic [UTC_W-1:0]     utc_acc;
        logic                 utc_frac;
        logic                 fix;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
        logic [3:0]           digits;
        logic [2:0]           frac;
        logic                 south;
        logic                 west;
    } t_rmc_track;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [THR_W-1:0]      i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [CHAR_W-1:0]     i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]   o_m_tuser;

    // Predictor state, expected fixes and the sentence being built.
    t_rmc_track        trk;
    logic              lock_m;
    logic [THR_W-1:0]  lock_thr;
    t_rmc_result       pending_fixes [$];
    logic [7:0]        line_q [$];
    bit                tx_idle_on = 1'b0;
    bit                aim_lock   = 1'b0;
    bit                all_nines  = 1'b0;
    int                n_chars    = 0;
    int                n_results  = 0;
    int                errors     = 0;
    int                stuck      = 0;
    int                rx_hold    = 0;
    int                rx_mode_left = 0;
    bit                rx_idle_on = 1'b0;

    // Directed sentences; the first four have their results written out.
    string dir_text [DIR_ROWS] = '{
        "GPRMC",
        ",,,",
        ",,,,,,,",
        ",999999,A,9060.0,S,18100.,W,",
        "$GPRMC,123519.00,A,4807.038,S,01131.000,E,022.4,084.4,230394,003.1,W*6A",
        ",,.5,V,12.3456,N,,E,"
    };
    bit dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    t_rmc_result dir_want [DIR_ROWS] = '{
        '{ST_NO_COMMA,   1'b0, 18'd0, 28'd0, 29'd0, 1'b0},
        '{ST_FEW_COMMAS, 1'b0, 18'd0, 28'd0, 29'd0, 1'b0},
        '{ST_OK,         1'b0, 18'd0, 28'd0, 29'd0, 1'b0},
        '{ST_OK, 1'b1, 18'd235959, 28'(-90000000), 29'(-180000000), 1'b0},
        '{ST_OK, 1'b0, 18'd0, 28'd0, 29'd0, 1'b0},
        '{ST_OK, 1'b0, 18'd0, 28'd0, 29'd0, 1'b0}
    };

    nmea_rmc_position_parser_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint ten_pow(input int n);
        longint p;
        p = 1;
        for (int k = 0; k < n; k++) p = p * 10;
        return p;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int pause_cycles();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // One character of a coordinate field: degrees, whole minutes, then fraction.
    function automatic void coord_char(input logic [7:0] c, input int deg_digits,
                                       input longint deg_max, inout logic [3:0] digits,
                                       inout logic [2:0] frac, inout longint deg,
                                       inout longint mins);
        longint d, m;
        if (c == CH_DOT) begin
            if (frac == 3'd0) frac = 3'd1;
        end else if (c >= CH_0 && c <= CH_9) begin
            d = longint'(c) - longint'(CH_0);
            if (frac != 3'd0) begin
                if (frac <= FRAC_DIGITS) begin
                    m = mins + d * ten_pow(FRAC_DIGITS - int'(frac));
                    mins = (m > longint'(MINUTE_MAX)) ? longint'(MINUTE_MAX) : m;
                end
                if (frac < 3'd7) frac++;
            end else if (digits < deg_digits) begin
                m = deg * 10 + d;
                deg = (m > deg_max) ? deg_max : m;
                if (digits < 4'd15) digits++;
            end else begin
                m = mins * 10 + d * ten_pow(FRAC_DIGITS);
                mins = (m > longint'(MINUTE_MAX)) ? longint'(MINUTE_MAX) : m;
                if (digits < 4'd15) digits++;
            end
        end
    endfunction

    function automatic longint to_microdeg(input longint deg, input longint mins,
                                           input longint cap);
        longint v;
        v = deg * 1000000 + (mins * ten_pow(6 - FRAC_DIGITS)) / 60;
        return (v > cap) ? cap : v;
    endfunction

    // Takes one character; returns 1 with the fix when the sentence ends.
    function automatic bit parse_char(inout t_rmc_track s, inout logic lk,
                                      input logic [THR_W-1:0] thr, input logic [7:0] c,
                                      input logic last, output t_rmc_result r);
        longint deg, mins, t, lat_mag, lon_mag;
        r = '0;
        if (lk) return 1'b0;
        if (c == CH_COMMA) begin
            if (s.commas < 3'd7) s.commas++;
            s.digits = '0;
            s.frac   = '0;
        end else begin
            case (s.commas)
                FLD_TIME: begin
                    if (c == CH_DOT) begin
                        s.utc_frac = 1'b1;
                    end else if (c >= CH_0 && c <= CH_9 && !s.utc_frac && s.digits < 4'd6) begin
                        t = longint'(s.utc_acc) * 10 + longint'(c) - longint'(CH_0);
                        s.utc_acc = (t > longint'(TIME_MAX)) ? TIME_MAX : UTC_W'(t);
                        if (s.digits < 4'd15) s.digits++;
                    end
                end
                FLD_STATUS: begin
                    if (s.digits == '0) s.fix = (c == CH_A);
                    if (s.digits < 4'd15) s.digits++;
                end
                FLD_LAT: begin
                    deg  = longint'(s.lat_deg);
                    mins = longint'(s.lat_min);
                    coord_char(c, 2, 99, s.digits, s.frac, deg, mins);
                    s.lat_deg = LAT_DEG_W'(deg);
                    s.lat_min = MIN_W'(mins);
                end
                FLD_NS: begin
                    if (s.digits == '0) s.south = (c == CH_S);
                    if (s.digits < 4'd15) s.digits++;
                end
                FLD_LON: begin
                    deg  = longint'(s.lon_deg);
                    mins = longint'(s.lon_min);
                    coord_char(c, 3, 255, s.digits, s.frac, deg, mins);
                    s.lon_deg = LON_DEG_W'(deg);
                    s.lon_min = MIN_W'(mins);
                end
                FLD_EW: begin
                    if (s.digits == '0) s.west = (c == CH_W);
                    if (s.digits < 4'd15) s.digits++;
                end
                default: ;
            endcase
        end
        if (!last) return 1'b0;

        if (s.commas == 3'd0)     r.status = ST_NO_COMMA;
        else if (s.commas < 3'd7) r.status = ST_FEW_COMMAS;
        else                      r.status = ST_OK;

        if (r.status == ST_OK) begin
            lat_mag = to_microdeg(longint'(s.lat_deg), longint'(s.lat_min), longint'(LAT_LIMIT));
            lon_mag = to_microdeg(longint'(s.lon_deg), longint'(s.lon_min), longint'(LON_LIMIT));
            r.fix = s.fix;
            r.utc = s.utc_acc;
            r.lat = LAT_W'(s.south ? -lat_mag : lat_mag);
            r.lon = LON_W'(s.west ? -lon_mag : lon_mag);
            if (!s.south && !s.west && lat_mag > longint'(thr) && lon_mag > longint'(thr))
                lk = 1'b1;
        end
        r.locked = lk;
        s = '0;
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    // Sentence construction.
    function automatic void add_text(input string txt);
        for (int k = 0; k < txt.len(); k++) line_q.push_back(txt[k]);
    endfunction

    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_COMMA) ? CH_PLUS : b;
    endfunction

    function automatic void add_digits(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0) line_q.push_back(stray_byte());
            line_q.push_back(all_nines ? CH_9 : 8'(CH_0 + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_coord(input int usual, input int most);
        add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, most) : usual);
        if ($urandom_range(0, 4) != 0) begin
            line_q.push_back(CH_DOT);
            add_digits($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) begin
                line_q.push_back(CH_DOT);
                add_digits(2);
            end
        end
    endfunction

    // A letter field: the usual letter, the other one, empty, or something odd.
    function automatic void add_letter(input logic [7:0] pos, input logic [7:0] neg);
        case ($urandom_range(0, 5))
            0, 1: line_q.push_back(pos);
            2, 3: line_q.push_back(neg);
            4:    ;
            default: begin
                line_q.push_back(stray_byte());
                if ($urandom_range(0, 1) == 0) line_q.push_back(neg);
            end
        endcase
    endfunction

    // Mostly well-formed sentences with random content, some cut short, some noise.
    function automatic void build_line();
        int kind, cut;
        line_q.delete();
        kind = $urandom_range(0, 19);
        all_nines = ($urandom_range(0, 9) == 0);
        if (kind < 3) begin
            repeat ($urandom_range(1, 16))
                line_q.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA
                                                              : 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 7) != 0) add_text("$GPRMC");
        else repeat ($urandom_range(0, 3)) line_q.push_back(stray_byte());
        line_q.push_back(CH_COMMA);
        add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 6);
        if ($urandom_range(0, 1) == 0) begin
            line_q.push_back(CH_DOT);
            add_digits($urandom_range(0, 3));
        end
        line_q.push_back(CH_COMMA);
        add_letter(CH_A, CH_V);
        line_q.push_back(CH_COMMA);
        add_coord(4, 7);
        line_q.push_back(CH_COMMA);
        if (aim_lock) line_q.push_back(CH_N);
        else          add_letter(CH_N, CH_S);
        line_q.push_back(CH_COMMA);
        add_coord(5, 8);
        line_q.push_back(CH_COMMA);
        if (aim_lock) line_q.push_back(CH_E);
        else          add_letter(CH_E, CH_W);
        line_q.push_back(CH_COMMA);
        case ($urandom_range(0, 2))
            0: ;
            1: repeat ($urandom_range(1, 5)) begin
                add_digits($urandom_range(0, 6));
                line_q.push_back(CH_COMMA);
            end
            default: repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if (kind < 6) begin
            cut = $urandom_range(1, line_q.size());
            while (line_q.size() > cut) void'(line_q.pop_back());
        end
    endfunction

    // Runs the built sentence on a copy of the predictor to see whether it locks.
    function automatic bit sentence_locks();
        t_rmc_track  s;
        logic        lk;
        t_rmc_result r;
        s  = trk;
        lk = lock_m;
        foreach (line_q[k])
            void'(parse_char(s, lk, lock_thr, line_q[k], k == line_q.size() - 1, r));
        return lk;
    endfunction

    // Offers one character, waits for it to be taken and predicts its effect.
    task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                             input t_rmc_result want);
        t_rmc_result r;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_chars++;
        if (parse_char(trk, lock_m, lock_thr, c, last, r))
            pending_fixes.push_back(typed ? want : r);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat (pause_cycles()) @(posedge i_clk);
        end
    endtask

    task automatic send_line(input bit typed, input t_rmc_result want);
        tx_idle_on = ($urandom_range(0, 9) < 7);
        foreach (line_q[k]) send_char(line_q[k], k == line_q.size() - 1, typed, want);
    endtask

    task automatic random_sentence(input bit avoid_lock);
        int tries;
        tries = 0;
        build_line();
        while (avoid_lock && sentence_locks()) begin
            tries++;
            if (tries >= 100) begin
                line_q.delete();
                add_text(",,,,,,,");
            end else begin
                build_line();
            end
        end
        send_line(1'b0, '0);
    endtask

    // Holds the sender until every expected fix is out and the pipeline is empty.
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lock_thr = v;
    endtask

    // Result side: stalls in bursts, with stretches of steady acceptance.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode_left <= $urandom_range(50, 400);
            rx_idle_on   <= ($urandom_range(0, 3) != 0);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (rx_hold != 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rx_hold    <= pause_cycles() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compares every fix that leaves the block with the oldest expected one.
    always @(posedge i_clk) begin : check_fixes
        t_rmc_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            got.status = t_status'(o_m_tuser);
            got.fix    = o_m_tdata[0];
            got.utc    = o_m_tdata[18:1];
            got.lat    = o_m_tdata[46:19];
            got.lon    = o_m_tdata[75:47];
            got.locked = o_m_tdata[76];
            if (pending_fixes.size() == 0) begin
                flag_error($sformatf("fix %0d arrived with none expected", n_results));
            end else begin
                want = pending_fixes.pop_front();
                if (got.status !== want.status)
                    flag_error($sformatf("fix %0d parse_status %0d, expected %0d",
                                         n_results, got.status, want.status));
                if (got.fix !== want.fix)
                    flag_error($sformatf("fix %0d fix_valid %0b, expected %0b",
                                         n_results, got.fix, want.fix));
                if (got.utc !== want.utc)
                    flag_error($sformatf("fix %0d utc_hhmmss %0d, expected %0d",
                                         n_results, got.utc, want.utc));
                if (got.lat !== want.lat)
                    flag_error($sformatf("fix %0d latitude %0d, expected %0d",
                                         n_results, $signed(got.lat), $signed(want.lat)));
                if (got.lon !== want.lon)
                    flag_error($sformatf("fix %0d longitude %0d, expected %0d",
                                         n_results, $signed(got.lon), $signed(want.lon)));
                if (got.locked !== want.locked)
                    flag_error($sformatf("fix %0d position_locked %0b, expected %0b",
                                         n_results, got.locked, want.locked));
            end
        end
    end

    // Ends the run if neither stream moves for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [THR_W-1:0] phase_thr [5];
        int phase_start;
        trk      = '0;
        lock_m   = 1'b0;
        lock_thr = THR_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short sentences for the parse errors, the limits and a textbook sentence.
        foreach (dir_text[i]) begin
            line_q.delete();
            add_text(dir_text[i]);
            send_line(dir_typed[i], dir_want[i]);
        end

        // Random sentences under several thresholds; none of them may lock here.
        phase_thr = '{28'd0, THR_TOP, 28'($urandom_range(0, 180000000)), LAT_LIMIT,
                      28'($urandom_range(0, 5000000))};
        foreach (phase_thr[p]) begin
            set_threshold(phase_thr[p]);
            phase_start = n_chars;
            while (n_chars - phase_start < PHASE_CHARS) random_sentence(1'b1);
        end

        // Drive towards a lock, then check that nothing more gets through.
        set_threshold(28'($urandom_range(0, 40000000)));
        aim_lock = 1'b1;
        for (int k = 0; k < 40 && !lock_m; k++) random_sentence(1'b0);
        aim_lock = 1'b0;
        set_threshold(THR_TOP);
        repeat (4) random_sentence(1'b0);
        wait_drain();

        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
